FILE: hdl/tfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tfp_pkg;

  localparam logic [7:0]  HdrA     = 8'h55;
  localparam logic [7:0]  HdrB     = 8'hAA;
  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'h1021;
  localparam logic [7:0]  FaultBit = 8'h01;
  localparam int unsigned CrcSpan  = 11;
  localparam int unsigned FrameLen = 15;

  localparam int unsigned PosW     = 4;
  localparam int unsigned CfgIdxW  = 8;

  // frame positions
  localparam logic [PosW-1:0] PosHunt   = 4'd0;
  localparam logic [PosW-1:0] PosHeadA  = 4'd1;
  localparam logic [PosW-1:0] PosVer    = 4'd2;
  localparam logic [PosW-1:0] PosType   = 4'd3;
  localparam logic [PosW-1:0] PosSeqLo  = 4'd4;
  localparam logic [PosW-1:0] PosSeqHi  = 4'd5;
  localparam logic [PosW-1:0] PosLen    = 4'd6;
  localparam logic [PosW-1:0] PosRpmLo  = 4'd7;
  localparam logic [PosW-1:0] PosRpmHi  = 4'd8;
  localparam logic [PosW-1:0] PosTmpLo  = 4'd9;
  localparam logic [PosW-1:0] PosTmpHi  = 4'd10;
  localparam logic [PosW-1:0] PosState  = 4'd11;
  localparam logic [PosW-1:0] PosFlags  = 4'd12;
  localparam logic [PosW-1:0] PosCrcEnd = PosW'(2 + CrcSpan);
  localparam logic [PosW-1:0] PosLast   = PosW'(FrameLen - 1);

  typedef enum logic [1:0] {
    StNone   = 2'd0,
    StOk     = 2'd1,
    StFormat = 2'd2,
    StCrc    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RegVersion  = 2'd0,
    RegType     = 2'd1,
    RegLength   = 2'd2,
    RegMaxState = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] expected_version;
    logic [7:0] expected_type;
    logic [7:0] expected_length;
    logic [7:0] max_state_code;
  } cfg_t;

  typedef struct packed {
    status_e            status;
    logic [15:0]        sequence_number;
    logic [15:0]        rpm;
    logic signed [15:0] temperature;
    logic [7:0]         vehicle_state;
    logic               fault_active;
  } res_t;

  // crc-16/ccitt-false, one byte msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/tfp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface tfp_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [15:0]        sequence_number;
  logic [15:0]        rpm;
  logic signed [15:0] temperature;
  logic [7:0]         vehicle_state;
  logic               fault_active;
  modport source (output valid, output status, output sequence_number, output rpm,
                  output temperature, output vehicle_state, output fault_active,
                  input ready);
  modport sink (input valid, input status, input sequence_number, input rpm,
                input temperature, input vehicle_state, input fault_active,
                output ready);
endinterface

interface tfp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/tfp_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module tfp_cfg_regs
  import tfp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_en_i,
  input  wire logic [CfgIdxW-1:0] wr_idx_i,
  input  wire logic [7:0]         wr_data_i,
  output      cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_idx_i)
        CfgIdxW'(RegVersion):  cfg_d.expected_version = wr_data_i;
        CfgIdxW'(RegType):     cfg_d.expected_type    = wr_data_i;
        CfgIdxW'(RegLength):   cfg_d.expected_length  = wr_data_i;
        CfgIdxW'(RegMaxState): cfg_d.max_state_code   = wr_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_version <= 8'd1;
      cfg_q.expected_type    <= 8'd1;
      cfg_q.expected_length  <= 8'd6;
      cfg_q.max_state_code   <= 8'd3;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hdl/tfp_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module tfp_parser
  import tfp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire cfg_t       cfg_i,
  output      res_t       res_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      bytes_q [PosVer:PosCrcEnd];
  logic            fmt_err;
  logic [15:0]     rx_crc;

  assign rx_crc  = {rx_byte_i, bytes_q[PosCrcEnd]};
  assign fmt_err = (bytes_q[PosVer] != cfg_i.expected_version) ||
                   (bytes_q[PosType] != cfg_i.expected_type) ||
                   (bytes_q[PosLen] != cfg_i.expected_length) ||
                   (bytes_q[PosState] > cfg_i.max_state_code);

  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    res_o = '0;
    res_o.status = StNone;
    if (accept_i) begin
      if (pos_q == PosHunt) begin
        if (rx_byte_i == HdrA) begin
          pos_d = PosHeadA;
        end
      end else if (pos_q == PosHeadA) begin
        if (rx_byte_i == HdrB) begin
          pos_d = PosVer;
          crc_d = CrcInit;
        end else if (rx_byte_i != HdrA) begin
          pos_d = PosHunt;
        end
      end else if (pos_q < PosLast) begin
        if (pos_q < PosCrcEnd) begin
          crc_d = crc_byte(crc_q, rx_byte_i);
        end
        pos_d = pos_q + PosW'(1);
      end else begin
        pos_d = PosHunt;
        if (fmt_err) begin
          res_o.status = StFormat;
        end else if (rx_crc != crc_q) begin
          res_o.status = StCrc;
        end else begin
          res_o.status          = StOk;
          res_o.sequence_number = {bytes_q[PosSeqHi], bytes_q[PosSeqLo]};
          res_o.rpm             = {bytes_q[PosRpmHi], bytes_q[PosRpmLo]};
          res_o.temperature     = {bytes_q[PosTmpHi], bytes_q[PosTmpLo]};
          res_o.vehicle_state   = bytes_q[PosState];
          res_o.fault_active    = |(bytes_q[PosFlags] & FaultBit);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosHunt;
      crc_q <= CrcInit;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
    end
  end

  // frame byte store: bytes 2..13, the payload and the low crc byte
  always_ff @(posedge clk_i) begin
    if (accept_i && (pos_q >= PosVer) && (pos_q <= PosCrcEnd)) begin
      bytes_q[pos_q] <= rx_byte_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tfp_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module tfp_out_buf
  import tfp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output      logic in_ready_o,
  input  wire res_t in_data_i,
  output      logic out_valid_o,
  input  wire logic out_ready_i,
  output      res_t out_data_o
);

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic in_acc;
  logic out_load;

  assign in_ready_o = !skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign out_load   = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_load) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_acc;
        out_d       = in_data_i;
      end
    end else if (in_acc) begin
      skid_valid_d = 1'b1;
      skid_d       = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: hdl/telemetry_frame_parser_crc16.sv
`timescale 1ns / 1ps
`default_nettype none

// Framed telemetry parser: every accepted byte gives exactly one result, one byte per clock
// sustained while the output buffer has room. The header 0x55 0xAA is hunted, the remaining
// 13 bytes are collected while a CRC-16/CCITT-FALSE over bytes 2..12 is updated one full
// byte per accepted byte, and the last byte yields status (format error before crc error)
// and, if ok, the decoded fields; every other byte yields status none with zero fields. The
// result is registered in the two-entry output buffer (output and skid register), which keeps
// the input flowing until both are full. Configuration writes are taken every cycle.

module telemetry_frame_parser_crc16
  import tfp_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  tfp_byte_if.sink   rx_i,
  tfp_res_if.source  res_o,
  tfp_cfg_if.sink    cfg_i
);

  cfg_t cfg;
  res_t res_new;
  res_t res_out;
  logic in_ready;
  logic accept;

  assign accept      = rx_i.valid && in_ready;
  assign rx_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  tfp_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  tfp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_i.rx_byte),
    .cfg_i     (cfg),
    .res_o     (res_new)
  );

  tfp_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_i.valid),
    .in_ready_o  (in_ready),
    .in_data_i   (res_new),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_data_o  (res_out)
  );

  assign res_o.status          = res_out.status;
  assign res_o.sequence_number = res_out.sequence_number;
  assign res_o.rpm             = res_out.rpm;
  assign res_o.temperature     = res_out.temperature;
  assign res_o.vehicle_state   = res_out.vehicle_state;
  assign res_o.fault_active    = res_out.fault_active;

endmodule

`default_nettype wire

FILE: hdl/tfp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tfp_checker
  import tfp_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [1:0]  status_i,
  input wire logic [15:0] sequence_number_i,
  input wire logic [15:0] rpm_i,
  input wire logic [15:0] temperature_i,
  input wire logic [7:0]  vehicle_state_i,
  input wire logic        fault_active_i
);

  // fields are zero unless the frame is ok
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (status_i != StOk)) |->
      (sequence_number_i == '0) && (rpm_i == '0) && (temperature_i == '0) &&
      (vehicle_state_i == '0) && !fault_active_i)
    else $error("nonzero fields on a result that is not ok");

  // a result appears only after a request was taken
  a_out_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result without a request");

  // input stalls only while a result waits
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with empty output");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i && $stable(status_i) &&
      $stable(sequence_number_i) && $stable(rpm_i) && $stable(temperature_i))
    else $error("stalled result changed");

endmodule

bind telemetry_frame_parser_crc16 tfp_checker u_tfp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (rx_i.valid),
  .in_ready_i        (rx_i.ready),
  .out_valid_i       (res_o.valid),
  .out_ready_i       (res_o.ready),
  .status_i          (res_o.status),
  .sequence_number_i (res_o.sequence_number),
  .rpm_i             (res_o.rpm),
  .temperature_i     (res_o.temperature),
  .vehicle_state_i   (res_o.vehicle_state),
  .fault_active_i    (res_o.fault_active)
);

`default_nettype wire

FILE: bench/tb_telemetry_frame_parser_crc16.sv
`timescale 1ns / 1ps

module tb_telemetry_frame_parser_crc16;
  import tfp_pkg::*;

  localparam int unsigned NumRegs       = 4;
  localparam int unsigned RandomBytes   = 120;
  localparam int unsigned SettleCycles  = 6;
  localparam int unsigned TailCycles    = 10;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned ReportLimit   = 40;
  localparam cfg_t        CfgReset      = '{8'd1, 8'd1, 8'd6, 8'd3};

  typedef enum int {
    KindGood,
    KindFormat,
    KindCrc,
    KindBoth
  } frame_kind_e;

  typedef struct {
    logic [7:0]  ver;
    logic [7:0]  typ;
    logic [15:0] seq;
    logic [7:0]  len;
    logic [15:0] rpm;
    logic [15:0] temp;
    logic [7:0]  vstate;
    logic [7:0]  flags;
    bit          crc_ok;
  } frame_t;

  logic clk;
  logic rst_n;

  tfp_byte_if rx_if ();
  tfp_res_if  res_if ();
  tfp_cfg_if  cfg_if ();

  telemetry_frame_parser_crc16 uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .rx_i  (rx_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  // parser model state
  cfg_t        cfg_model;
  logic [3:0]  frame_pos;
  logic [15:0] running_crc;
  logic [7:0]  frame_buf [FrameLen];

  res_t        awaited_reports [$];
  int unsigned fail_count;
  int unsigned sent_bytes;
  int unsigned stuck_cycles;
  bit          tx_gaps_on;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  function automatic res_t track_byte(input logic [7:0] b);
    res_t        r;
    logic [15:0] rx_crc;
    r = '0;
    r.status = StNone;
    if (frame_pos == PosHunt) begin
      if (b == HdrA) begin
        frame_buf[0] = b;
        frame_pos = PosHeadA;
      end
    end else if (frame_pos == PosHeadA) begin
      if (b == HdrB) begin
        frame_buf[1] = b;
        frame_pos = PosVer;
        running_crc = CrcInit;
      end else if (b != HdrA) begin
        frame_pos = PosHunt;
      end
    end else if (frame_pos < PosLast) begin
      frame_buf[frame_pos] = b;
      if (frame_pos < PosCrcEnd) begin
        running_crc = crc_update(running_crc, b);
      end
      frame_pos = frame_pos + 4'd1;
    end else begin
      frame_buf[PosLast] = b;
      rx_crc = {frame_buf[PosLast], frame_buf[PosCrcEnd]};
      if (frame_buf[PosVer] != cfg_model.expected_version ||
          frame_buf[PosType] != cfg_model.expected_type ||
          frame_buf[PosLen] != cfg_model.expected_length ||
          frame_buf[PosState] > cfg_model.max_state_code) begin
        r.status = StFormat;
      end else if (rx_crc != running_crc) begin
        r.status = StCrc;
      end else begin
        r.status          = StOk;
        r.sequence_number = {frame_buf[PosSeqHi], frame_buf[PosSeqLo]};
        r.rpm             = {frame_buf[PosRpmHi], frame_buf[PosRpmLo]};
        r.temperature     = {frame_buf[PosTmpHi], frame_buf[PosTmpLo]};
        r.vehicle_state   = frame_buf[PosState];
        r.fault_active    = frame_buf[PosFlags][0];
      end
      frame_pos = PosHunt;
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!tx_gaps_on || r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 50);
  endfunction

  function automatic int unsigned pick_stall();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 2);
    end else if (r < 95) begin
      return $urandom_range(3, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic frame_t random_frame(input frame_kind_e kind);
    frame_t f;
    f.ver    = cfg_model.expected_version;
    f.typ    = cfg_model.expected_type;
    f.len    = cfg_model.expected_length;
    f.seq    = 16'($urandom);
    f.rpm    = 16'($urandom);
    f.temp   = 16'($urandom);
    f.vstate = 8'($urandom_range(0, cfg_model.max_state_code));
    f.flags  = 8'($urandom);
    f.crc_ok = !(kind == KindCrc || kind == KindBoth);
    if (kind == KindFormat || kind == KindBoth) begin
      case ($urandom_range(0, 3))
        0: f.ver = f.ver ^ 8'($urandom_range(1, 255));
        1: f.typ = f.typ ^ 8'($urandom_range(1, 255));
        2: f.len = f.len ^ 8'($urandom_range(1, 255));
        default: begin
          if (cfg_model.max_state_code != 8'hFF) begin
            f.vstate = 8'($urandom_range(cfg_model.max_state_code + 1, 255));
          end else begin
            f.ver = f.ver ^ 8'($urandom_range(1, 255));
          end
        end
      endcase
    end
    return f;
  endfunction

  task automatic flag_field(input string fname, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= ReportLimit) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    awaited_reports.push_back(track_byte(b));
    sent_bytes++;
  endtask

  task automatic send_frame(input frame_t f);
    logic [7:0]  fr [FrameLen];
    logic [15:0] crc;
    int          i;
    fr[0]        = HdrA;
    fr[1]        = HdrB;
    fr[PosVer]   = f.ver;
    fr[PosType]  = f.typ;
    fr[PosSeqLo] = f.seq[7:0];
    fr[PosSeqHi] = f.seq[15:8];
    fr[PosLen]   = f.len;
    fr[PosRpmLo] = f.rpm[7:0];
    fr[PosRpmHi] = f.rpm[15:8];
    fr[PosTmpLo] = f.temp[7:0];
    fr[PosTmpHi] = f.temp[15:8];
    fr[PosState] = f.vstate;
    fr[PosFlags] = f.flags;
    crc = CrcInit;
    for (i = PosVer; i < PosCrcEnd; i++) begin
      crc = crc_update(crc, fr[i]);
    end
    if (!f.crc_ok) begin
      crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    end
    fr[PosCrcEnd] = crc[7:0];
    fr[PosLast]   = crc[15:8];
    for (i = 0; i < FrameLen; i++) begin
      send_byte(fr[i]);
    end
  endtask

  // wait until every request has its result and the pipeline is empty
  task automatic settle();
    rx_if.valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    if (idx < NumRegs) begin
      case (reg_idx_e'(idx[1:0]))
        RegVersion:  cfg_model.expected_version = val;
        RegType:     cfg_model.expected_type = val;
        RegLength:   cfg_model.expected_length = val;
        RegMaxState: cfg_model.max_state_code = val;
        default: ;
      endcase
    end
    @(posedge clk);
  endtask

  task automatic apply_config(input cfg_t c);
    settle();
    write_reg(8'(RegVersion), c.expected_version);
    write_reg(8'(RegType), c.expected_type);
    write_reg(8'(RegLength), c.expected_length);
    write_reg(8'(RegMaxState), c.max_state_code);
    write_reg(8'($urandom_range(NumRegs, 255)), 8'($urandom));
  endtask

  task automatic test_reset_frames();
    frame_t f;
    tx_gaps_on = 1'b0;
    f = random_frame(KindGood);
    f.seq = 16'h0000;
    f.rpm = 16'h0000;
    f.temp = 16'h8000;
    f.vstate = 8'h00;
    f.flags = 8'hFE;
    send_frame(f);
    f.seq = 16'hFFFF;
    f.rpm = 16'hFFFF;
    f.temp = 16'h7FFF;
    f.vstate = cfg_model.max_state_code;
    f.flags = 8'h01;
    send_frame(f);
    f.seq = 16'hAA55;
    f.temp = 16'hFFFF;
    f.flags = 8'hFF;
    send_frame(f);
    f = random_frame(KindGood);
    f.vstate = cfg_model.max_state_code + 8'd1;
    send_frame(f);
    f = random_frame(KindCrc);
    send_frame(f);
    // format error wins over crc error
    f = random_frame(KindCrc);
    f.ver = ~cfg_model.expected_version;
    send_frame(f);
    f = random_frame(KindGood);
    f.typ = cfg_model.expected_type + 8'd1;
    send_frame(f);
    f = random_frame(KindGood);
    f.len = 8'hFF;
    send_frame(f);
  endtask

  task automatic test_header_hunt();
    tx_gaps_on = 1'b1;
    send_byte(HdrB);
    send_byte(HdrA);
    send_byte(8'h00);
    send_byte(HdrA);
    send_byte(8'hFF);
    send_byte(HdrB);
    // repeated sync byte keeps the header start
    send_byte(HdrA);
    send_byte(HdrA);
    send_frame(random_frame(KindGood));
    send_byte(HdrA);
    send_byte(HdrB);
    repeat (13) send_byte(8'($urandom));
    send_frame(random_frame(KindGood));
  endtask

  task automatic test_register_sweep();
    cfg_t settings [5];
    settings[0] = '{8'h00, 8'h00, 8'h00, 8'h00};
    settings[1] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    settings[2] = cfg_t'($urandom);
    settings[3] = '{8'h55, 8'hAA, 8'h80, 8'h7F};
    settings[4] = CfgReset;
    foreach (settings[i]) begin
      apply_config(settings[i]);
      repeat (3) begin
        send_frame(random_frame(KindGood));
        send_frame(random_frame(frame_kind_e'($urandom_range(0, 3))));
      end
    end
  endtask

  task automatic test_drain_pause();
    repeat (4) begin
      send_frame(random_frame(KindGood));
      send_byte(8'($urandom));
      settle();
    end
  endtask

  task automatic test_random_stream();
    cfg_t        c;
    int unsigned start;
    int unsigned r;
    c = CfgReset;
    if ($urandom_range(0, 1)) c.expected_version = 8'($urandom);
    if ($urandom_range(0, 1)) c.expected_type = 8'($urandom);
    if ($urandom_range(0, 1)) c.expected_length = 8'($urandom);
    c.max_state_code = 8'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom);
    apply_config(c);
    start = sent_bytes;
    while (sent_bytes - start < RandomBytes) begin
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 55) begin
        send_frame(random_frame(KindGood));
      end else if (r < 67) begin
        send_frame(random_frame($urandom_range(0, 1) ? KindFormat : KindBoth));
      end else if (r < 77) begin
        send_frame(random_frame(KindCrc));
      end else if (r < 88) begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 2))
            0: send_byte(HdrA);
            1: send_byte(HdrB);
            default: send_byte(8'($urandom));
          endcase
        end
      end else if (r < 97) begin
        // cut-off frame, the next bytes fill it up
        send_byte(HdrA);
        send_byte(HdrB);
        repeat ($urandom_range(0, 12)) send_byte(8'($urandom));
      end else begin
        settle();
      end
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (awaited_reports.size() == 0) begin
        fail_count++;
        if (fail_count <= ReportLimit) begin
          $display("%0t: unexpected result, expected none, actual status %0d",
                   $time, res_if.status);
        end
      end else begin
        want = awaited_reports.pop_front();
        flag_field("status", want.status, res_if.status);
        flag_field("sequence_number", want.sequence_number, res_if.sequence_number);
        flag_field("rpm", want.rpm, res_if.rpm);
        flag_field("temperature", want.temperature, res_if.temperature);
        flag_field("vehicle_state", want.vehicle_state, res_if.vehicle_state);
        flag_field("fault_active", want.fault_active, res_if.fault_active);
      end
    end
  end

  always @(posedge clk) begin
    if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    res_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 120 : 8)) @(posedge clk);
      res_if.ready <= 1'b0;
      repeat (pick_stall()) @(posedge clk);
    end
  end

  initial begin
    rst_n         = 1'b0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= 8'h00;
    cfg_if.data   <= 8'h00;
    cfg_model     = CfgReset;
    frame_pos     = PosHunt;
    running_crc   = CrcInit;
    fail_count    = 0;
    sent_bytes    = 0;
    stuck_cycles  = 0;
    tx_gaps_on    = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_frames();
    test_header_hunt();
    test_register_sweep();
    test_drain_pause();
    test_random_stream();

    rx_if.valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/tfp_pkg.sv
hdl/tfp_if.sv
hdl/tfp_cfg_regs.sv
hdl/tfp_parser.sv
hdl/tfp_out_buf.sv
hdl/telemetry_frame_parser_crc16.sv
hdl/tfp_checker.sv
bench/tb_telemetry_frame_parser_crc16.sv
